### hdl/tme_pkg.sv
package tme_pkg;

  localparam int TapeCellsDefault  = 512;
  localparam int StackDepthDefault = 256;

  localparam logic [15:0] CellMaxReset = 16'd259;
  localparam logic [15:0] SkipMax      = 16'hFFFF;

  // command bytes
  localparam logic [7:0] OpOpen  = 8'h5B;
  localparam logic [7:0] OpClose = 8'h5D;
  localparam logic [7:0] OpDot   = 8'h2E;
  localparam logic [7:0] OpComma = 8'h2C;
  localparam logic [7:0] OpLeft  = 8'h3C;
  localparam logic [7:0] OpRight = 8'h3E;
  localparam logic [7:0] OpMinus = 8'h2D;
  localparam logic [7:0] OpPlus  = 8'h2B;

  typedef enum logic [1:0] {
    StRunning   = 2'd0,
    StUnmatched = 2'd1,
    StEmptyLoop = 2'd2,
    StOverflow  = 2'd3
  } status_e;

  // state updates requested by the execute logic
  typedef struct packed {
    logic        tape_we;
    logic [15:0] tape_wdata;
    logic        push;
    logic        pop;
    logic        ptr_inc;
    logic        ptr_dec;
    logic [15:0] skip_depth;
    logic        did_action;
    status_e     status;
  } ctl_t;

  // one result item
  typedef struct packed {
    logic [15:0] next_pos;
    logic        out_valid;
    logic [7:0]  out_char;
    status_e     status;
  } rsp_t;

endpackage

### hdl/tme_req_if.sv
interface tme_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] instr;
  logic [15:0] pos;
  logic [7:0] in_char;

  modport source (output valid, output instr, output pos, output in_char, input ready);
  modport sink (input valid, input instr, input pos, input in_char, output ready);
endinterface

### hdl/tme_rsp_if.sv
interface tme_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pos;
  logic        out_valid;
  logic [7:0]  out_char;
  logic [1:0]  status;

  modport source (output valid, output next_pos, output out_valid, output out_char,
                  output status, input ready);
  modport sink (input valid, input next_pos, input out_valid, input out_char,
                input status, output ready);
endinterface

### hdl/tme_cfg_if.sv
interface tme_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/tme_ram.sv
module tme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hdl/tme_exec.sv
module tme_exec (
  input  logic             [7:0]  instr_i,
  input  logic             [15:0] pos_i,
  input  logic             [7:0]  in_char_i,
  input  logic             [15:0] cell_i,
  input  logic             [15:0] top_i,
  input  logic                    stk_empty_i,
  input  logic                    stk_full_i,
  input  logic             [15:0] skip_depth_i,
  input  logic                    did_action_i,
  input  tme_pkg::status_e        status_i,
  input  logic             [15:0] cell_max_i,
  output tme_pkg::ctl_t           ctl_o,
  output tme_pkg::rsp_t           rsp_o
);

  always_comb begin
    ctl_o            = '0;
    ctl_o.skip_depth = skip_depth_i;
    ctl_o.did_action = did_action_i;
    ctl_o.status     = status_i;
    rsp_o            = '0;
    rsp_o.next_pos   = pos_i + 16'd1;

    if (status_i != tme_pkg::StRunning) begin
      // halted: hold everything
      rsp_o.next_pos = pos_i;
    end else if (skip_depth_i != 16'd0) begin
      if (instr_i == tme_pkg::OpOpen) begin
        if (skip_depth_i != tme_pkg::SkipMax) begin
          ctl_o.skip_depth = skip_depth_i + 16'd1;
        end
      end else if (instr_i == tme_pkg::OpClose) begin
        ctl_o.skip_depth = skip_depth_i - 16'd1;
      end
    end else begin
      case (instr_i)
        tme_pkg::OpOpen: begin
          if (cell_i != 16'd0) begin
            if (stk_full_i) begin
              ctl_o.status   = tme_pkg::StOverflow;
              rsp_o.next_pos = pos_i;
            end else begin
              ctl_o.push       = 1'b1;
              ctl_o.did_action = 1'b0;
            end
          end else begin
            ctl_o.skip_depth = 16'd1;
          end
        end
        tme_pkg::OpClose: begin
          if (stk_empty_i) begin
            ctl_o.status   = tme_pkg::StUnmatched;
            rsp_o.next_pos = pos_i;
          end else begin
            ctl_o.pop      = 1'b1;
            rsp_o.next_pos = top_i;
            if (!did_action_i) begin
              ctl_o.status = tme_pkg::StEmptyLoop;
            end
          end
        end
        tme_pkg::OpDot: begin
          rsp_o.out_valid = 1'b1;
          rsp_o.out_char  = cell_i[7:0];
        end
        tme_pkg::OpComma: begin
          ctl_o.tape_we    = 1'b1;
          ctl_o.tape_wdata = {8'd0, in_char_i};
          ctl_o.did_action = 1'b1;
        end
        tme_pkg::OpLeft: begin
          ctl_o.ptr_dec    = 1'b1;
          ctl_o.did_action = 1'b1;
        end
        tme_pkg::OpRight: begin
          ctl_o.ptr_inc    = 1'b1;
          ctl_o.did_action = 1'b1;
        end
        tme_pkg::OpMinus: begin
          ctl_o.tape_we    = 1'b1;
          ctl_o.tape_wdata = (cell_i == 16'd0) ? cell_max_i : cell_i - 16'd1;
          ctl_o.did_action = 1'b1;
        end
        tme_pkg::OpPlus: begin
          ctl_o.tape_we    = 1'b1;
          ctl_o.tape_wdata = (cell_i >= cell_max_i) ? 16'd0 : cell_i + 16'd1;
          ctl_o.did_action = 1'b1;
        end
        default: begin
        end
      endcase
    end

    rsp_o.status = ctl_o.status;
  end
endmodule

### hdl/tape_machine_instruction_executor.sv
// Tape machine instruction executor.
// Channels: in_i carries one request per program byte (instr, pos, in_char);
// out_o returns exactly one result per request, in order (next_pos, out_valid,
// out_char, status). cfg_i writes cell_max; it is always ready and is meant to
// be written only while no request is in flight.
//
// A request passes through the input register and then the result register
// before its result shows on out_o. Throughput is one request per cycle while
// out_o.ready stays high: each request does a single read-modify-write of the
// current tape cell and a single loop-stack access. Both memories are read
// every cycle at the address the next request will use, and a write made in
// the same cycle is forwarded, so no bubble follows a tape or stack update.
//
// Reset: all control state clears and cell_max returns to 259. The tape is
// then zeroed by a clearing pass over all TAPE_CELLS cells (512 by default),
// one cell a cycle, during which in_i.ready stays low. The loop stack is not
// cleared; it is read every cycle, but no slot is used before it is written.
// Stall: while out_o.ready is low the result register holds; one more request
// is still taken into the input register, then in_i.ready drops.
module tape_machine_instruction_executor #(
  parameter int TAPE_CELLS  = tme_pkg::TapeCellsDefault,
  parameter int STACK_DEPTH = tme_pkg::StackDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tme_req_if.sink   in_i,
  tme_rsp_if.source out_o,
  tme_cfg_if.sink   cfg_i
);
  localparam int PtrW = $clog2(TAPE_CELLS);
  localparam int StkAw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(TAPE_CELLS - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

  // clearing pass
  logic            clr_busy_q;
  logic [PtrW-1:0] clr_cnt_q;

  // input register
  logic        in_vld_q;
  logic [7:0]  instr_q;
  logic [15:0] pos_q;
  logic [7:0]  ch_q;

  // architectural state
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      skip_q;
  logic             act_q;
  tme_pkg::status_e status_q;
  logic [15:0]      cell_max_q;

  // forwarding of same-cycle memory writes
  logic        tfwd_q;
  logic [15:0] tfwd_data_q;
  logic        sfwd_q;
  logic [15:0] sfwd_data_q;

  // result register
  logic          out_vld_q;
  tme_pkg::rsp_t rsp_q;

  logic          adv, exec_fire, in_fire;
  tme_pkg::ctl_t ctl;
  tme_pkg::rsp_t rsp;
  logic [15:0]   tape_rdata, stk_rdata, cur_cell, top;
  logic          tape_we;
  logic [PtrW-1:0] tape_waddr;
  logic [15:0]   tape_wdata;
  logic [CntW-1:0] cnt_dec;
  logic [StkAw-1:0] stk_raddr;

  // advance the execute stage when the result register is free or draining
  assign adv       = !out_vld_q || out_o.ready;
  assign exec_fire = in_vld_q && adv;
  assign in_i.ready = !clr_busy_q && (!in_vld_q || adv);
  assign in_fire   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cur_cell = tfwd_q ? tfwd_data_q : tape_rdata;
  assign top      = sfwd_q ? sfwd_data_q : stk_rdata;

  tme_exec u_exec (
    .instr_i      (instr_q),
    .pos_i        (pos_q),
    .in_char_i    (ch_q),
    .cell_i       (cur_cell),
    .top_i        (top),
    .stk_empty_i  (cnt_q == '0),
    .stk_full_i   (cnt_q == CntFull),
    .skip_depth_i (skip_q),
    .did_action_i (act_q),
    .status_i     (status_q),
    .cell_max_i   (cell_max_q),
    .ctl_o        (ctl),
    .rsp_o        (rsp)
  );

  // pointer and stack count after the executing request
  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (exec_fire) begin
      if (ctl.ptr_inc) begin
        ptr_d = (ptr_q == PtrLast) ? '0 : ptr_q + PtrW'(1);
      end else if (ctl.ptr_dec) begin
        ptr_d = (ptr_q == '0) ? PtrLast : ptr_q - PtrW'(1);
      end
      if (ctl.push) begin
        cnt_d = cnt_q + CntW'(1);
      end else if (ctl.pop) begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  // tape port: sweep zeros after reset, otherwise write back the current cell
  assign tape_we    = clr_busy_q || (exec_fire && ctl.tape_we);
  assign tape_waddr = clr_busy_q ? clr_cnt_q : ptr_q;
  assign tape_wdata = clr_busy_q ? 16'd0 : ctl.tape_wdata;

  tme_ram #(
    .WIDTH (16),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (ptr_d),
    .rdata_o (tape_rdata)
  );

  // stack port: read the new top of stack every cycle
  assign cnt_dec   = cnt_d - CntW'(1);
  assign stk_raddr = (cnt_d == '0) ? '0 : StkAw'(cnt_dec);

  tme_ram #(
    .WIDTH (16),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (exec_fire && ctl.push),
    .waddr_i (StkAw'(cnt_q)),
    .wdata_i (pos_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      in_vld_q   <= 1'b0;
      ptr_q      <= '0;
      cnt_q      <= '0;
      skip_q     <= '0;
      act_q      <= 1'b0;
      status_q   <= tme_pkg::StRunning;
      cell_max_q <= tme_pkg::CellMaxReset;
      tfwd_q     <= 1'b0;
      sfwd_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        if (clr_cnt_q == PtrLast) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + PtrW'(1);
        end
      end

      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (exec_fire) begin
        in_vld_q <= 1'b0;
      end

      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (exec_fire) begin
        skip_q   <= ctl.skip_depth;
        act_q    <= ctl.did_action;
        status_q <= ctl.status;
      end

      if (cfg_i.valid) begin
        cell_max_q <= cfg_i.data;
      end

      tfwd_q <= exec_fire && ctl.tape_we;
      sfwd_q <= exec_fire && ctl.push;

      if (exec_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      instr_q <= in_i.instr;
      pos_q   <= in_i.pos;
      ch_q    <= in_i.in_char;
    end
    tfwd_data_q <= ctl.tape_wdata;
    sfwd_data_q <= pos_q;
    if (exec_fire) begin
      rsp_q <= rsp;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.next_pos  = rsp_q.next_pos;
  assign out_o.out_valid = rsp_q.out_valid;
  assign out_o.out_char  = rsp_q.out_char;
  assign out_o.status    = rsp_q.status;
endmodule

### hdl/tme_checker.sv
module tme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] next_pos_i,
  input logic        out_valid_i,
  input logic [7:0]  out_char_i,
  input logic [1:0]  status_i
);
  logic       rsp_fire;
  logic [1:0] last_status_q;

  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // track the status of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_status_q <= tme_pkg::StRunning;
    end else if (rsp_fire) begin
      last_status_q <= status_i;
    end
  end

  // a stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(next_pos_i)
      && $stable(out_valid_i) && $stable(out_char_i) && $stable(status_i))
    else $error("result changed while stalled");

  // once halted, the status never changes
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && last_status_q != tme_pkg::StRunning |-> status_i == last_status_q)
    else $error("halt status not sticky");

  // a halted block emits nothing
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && last_status_q != tme_pkg::StRunning |-> !out_valid_i && out_char_i == 8'd0)
    else $error("output emitted while halted");

  // no character without an output command
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && !out_valid_i |-> out_char_i == 8'd0)
    else $error("character present without output");
endmodule

bind tape_machine_instruction_executor tme_checker u_tme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (out_o.valid),
  .rsp_ready_i (out_o.ready),
  .next_pos_i  (out_o.next_pos),
  .out_valid_i (out_o.out_valid),
  .out_char_i  (out_o.out_char),
  .status_i    (out_o.status)
);

### tb/sv/tb_tape_machine_instruction_executor.sv
module tb_tape_machine_instruction_executor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPE_CELLS    = tme_pkg::TapeCellsDefault;
  localparam int STACK_DEPTH   = tme_pkg::StackDepthDefault;
  localparam int GAP_MAX       = 16;       // longest idle stretch per request, either side
  localparam int HOLD_CYCLES   = 200;      // long receiver hold-off to back the block up
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PRINT_MAX     = 40;       // mismatch lines shown; the count keeps going
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  tme_req_if req_if ();
  tme_rsp_if rsp_if ();
  tme_cfg_if cfg_if ();

  tape_machine_instruction_executor #(
    .TAPE_CELLS  (TAPE_CELLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Machine state as the testbench sees it. Every accepted request advances it
  // once, in acceptance order, and the answer goes to the back of the queue.
  // ---------------------------------------------------------------------------
  logic [15:0]      cell_mem    [TAPE_CELLS];
  int               cell_ptr    = 0;
  logic [15:0]      loop_starts [STACK_DEPTH];  // only read below loop_depth, so no reset
  int               loop_depth  = 0;
  logic [15:0]      skip_level  = '0;           // nonzero: scanning forward for the match
  bit               acted       = 1'b0;         // loop body did real work since its open
  tme_pkg::status_e halt        = tme_pkg::StRunning;
  logic [15:0]      cell_limit  = tme_pkg::CellMaxReset;

  tme_pkg::rsp_t expected_rsp [$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;

  // Sender bookkeeping: req_live means valid was left high after the last
  // acceptance because the next request follows back to back.
  int  next_gap = 0;
  bit  req_live = 1'b0;
  bit  quiet    = 1'b0;   // no idling on either side while set

  function automatic tme_pkg::rsp_t outcome(input logic [15:0] next_pos,
                                            input logic out_valid,
                                            input logic [7:0] out_char,
                                            input tme_pkg::status_e status);
    tme_pkg::rsp_t res;
    res.next_pos  = next_pos;
    res.out_valid = out_valid;
    res.out_char  = out_char;
    res.status    = status;
    return res;
  endfunction

  // Execute one program byte against the machine state and return its result.
  function automatic tme_pkg::rsp_t execute(input logic [7:0] op, input logic [15:0] pos,
                                            input logic [7:0] ch);
    tme_pkg::rsp_t res;
    logic [15:0]   cur;
    cur = cell_mem[cell_ptr];
    res = outcome(pos + 16'd1, 1'b0, 8'h00, tme_pkg::StRunning);
    if (halt != tme_pkg::StRunning) begin
      // Halted: nothing moves, the fetch stays put.
      res.next_pos = pos;
    end else if (skip_level != '0) begin
      // Skipping: only brackets count, nesting saturates at the top.
      if (op == tme_pkg::OpOpen && skip_level != tme_pkg::SkipMax) skip_level++;
      else if (op == tme_pkg::OpClose) skip_level--;
    end else begin
      case (op)
        tme_pkg::OpOpen: begin
          if (cur == '0) begin
            skip_level = 16'd1;
          end else if (loop_depth >= STACK_DEPTH) begin
            halt = tme_pkg::StOverflow;
            res.next_pos = pos;
          end else begin
            loop_starts[loop_depth] = pos;
            loop_depth++;
            acted = 1'b0;
          end
        end
        tme_pkg::OpClose: begin
          if (loop_depth == 0) begin
            halt = tme_pkg::StUnmatched;
            res.next_pos = pos;
          end else begin
            loop_depth--;
            res.next_pos = loop_starts[loop_depth];
            if (!acted) halt = tme_pkg::StEmptyLoop;
          end
        end
        tme_pkg::OpDot: begin
          res.out_valid = 1'b1;
          res.out_char  = cur[7:0];
        end
        tme_pkg::OpComma: begin
          cell_mem[cell_ptr] = {8'h00, ch};
          acted = 1'b1;
        end
        tme_pkg::OpLeft: begin
          cell_ptr = (cell_ptr == 0) ? TAPE_CELLS - 1 : cell_ptr - 1;
          acted = 1'b1;
        end
        tme_pkg::OpRight: begin
          cell_ptr = (cell_ptr >= TAPE_CELLS - 1) ? 0 : cell_ptr + 1;
          acted = 1'b1;
        end
        tme_pkg::OpMinus: begin
          cell_mem[cell_ptr] = (cur == '0) ? cell_limit : cur - 16'd1;
          acted = 1'b1;
        end
        tme_pkg::OpPlus: begin
          // A cell above the limit also wraps straight to zero.
          cell_mem[cell_ptr] = (cur >= cell_limit) ? 16'h0000 : cur + 16'd1;
          acted = 1'b1;
        end
        default: ;
      endcase
    end
    res.status = halt;
    return res;
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("[%0t] result %0d: %s got 'h%0h, want 'h%0h", $realtime, results_seen,
               what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Hold valid across back-to-back requests; drop it only when
  // a gap follows, so valid never sees two updates in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] op, input logic [15:0] pos,
                              input logic [7:0] ch, input bit typed = 1'b0,
                              input tme_pkg::rsp_t want = '0);
    tme_pkg::rsp_t calc;
    if (!req_live) repeat (next_gap) @(posedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.instr   <= op;
    req_if.pos     <= pos;
    req_if.in_char <= ch;
    do @(posedge clk_i); while (!req_if.ready);
    // Accepted at this edge: advance the machine and queue the answer. Rows
    // with a hand-written answer still run through execute to keep state.
    calc = execute(op, pos, ch);
    expected_rsp.push_back(typed ? want : calc);
    next_gap = draw_gap();
    req_live = (next_gap == 0);
    if (!req_live) req_if.valid <= 1'b0;
  endtask

  // Stop offering and wait until every request has its result back.
  task automatic drain_requests();
    if (req_live) begin
      req_if.valid <= 1'b0;
      req_live = 1'b0;
    end
    @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  // The register is only touched with nothing in flight.
  task automatic write_cell_max(input logic [15:0] value);
    drain_requests();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cell_limit = value;
  endtask

  // Draw one request that keeps the program well formed: a close only when it
  // matches an open whose body did work, and no push onto a full stack. Deep
  // mode favors opens on nonzero cells to grow the loop stack.
  task automatic random_request(input bit deep);
    logic [7:0]  op;
    logic [15:0] pos;
    logic [7:0]  ch;
    logic [15:0] cur;
    int          r;
    cur = cell_mem[cell_ptr];
    r   = $urandom_range(0, 99);
    ch  = 8'($urandom_range(0, 255));
    pos = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) == 0) pos = {16{pos[0]}};
    if (skip_level != '0) begin
      if (r < 35)      op = tme_pkg::OpClose;
      else if (r < 50) op = tme_pkg::OpOpen;
      else             op = 8'($urandom_range(0, 255));
    end else if (deep) begin
      if (cur == '0) begin
        op = tme_pkg::OpComma;
        ch = ch | 8'h01;
      end else if (r < 50) begin
        op = tme_pkg::OpOpen;
      end else if (r < 58) begin
        op = tme_pkg::OpClose;
      end else begin
        case (r % 5)
          0:       op = tme_pkg::OpPlus;
          1:       op = tme_pkg::OpMinus;
          2:       op = tme_pkg::OpLeft;
          3:       op = tme_pkg::OpRight;
          default: op = tme_pkg::OpDot;
        endcase
      end
    end else begin
      if (r < 10)      op = 8'($urandom_range(0, 255));
      else if (r < 24) op = tme_pkg::OpPlus;
      else if (r < 36) op = tme_pkg::OpMinus;
      else if (r < 44) op = tme_pkg::OpLeft;
      else if (r < 52) op = tme_pkg::OpRight;
      else if (r < 60) op = tme_pkg::OpComma;
      else if (r < 70) op = tme_pkg::OpDot;
      else if (r < 84) op = tme_pkg::OpOpen;
      else             op = tme_pkg::OpClose;
    end
    if (skip_level == '0) begin
      if (op == tme_pkg::OpClose && (loop_depth == 0 || !acted)) op = tme_pkg::OpRight;
      if (op == tme_pkg::OpOpen && cur != '0 && loop_depth >= STACK_DEPTH)
        op = tme_pkg::OpLeft;
    end
    send_request(op, pos, ch);
  endtask

  // ---------------------------------------------------------------------------
  // Directed script: one row per request or register write.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit            cfg_write;
    logic [15:0]   cfg_value;
    logic [7:0]    op;
    logic [15:0]   pos;
    logic [7:0]    ch;
    bit            typed;
    tme_pkg::rsp_t want;
  } script_row_t;

  script_row_t script [$];

  function automatic void row(input logic [7:0] op, input logic [15:0] pos,
                              input logic [7:0] ch);
    script_row_t s;
    s = '{cfg_write: 1'b0, cfg_value: '0, op: op, pos: pos, ch: ch, typed: 1'b0, want: '0};
    script.push_back(s);
  endfunction

  function automatic void row_exp(input logic [7:0] op, input logic [15:0] pos,
                                  input logic [7:0] ch, input logic [15:0] next_pos,
                                  input logic ov, input logic [7:0] oc);
    script_row_t s;
    s = '{cfg_write: 1'b0, cfg_value: '0, op: op, pos: pos, ch: ch, typed: 1'b1,
          want: outcome(next_pos, ov, oc, tme_pkg::StRunning)};
    script.push_back(s);
  endfunction

  function automatic void row_cfg(input logic [15:0] value);
    script_row_t s;
    s = '{cfg_write: 1'b1, cfg_value: value, op: '0, pos: '0, ch: '0, typed: 1'b0,
          want: '0};
    script.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: take results with random stalls, plus two long hold-offs that
  // let the block fill and push back on the request channel.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int            hold;
    tme_pkg::rsp_t want;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    rsp_if.ready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!rsp_if.valid);
      if (expected_rsp.size() == 0) begin
        report_mismatch("result with no request pending, next_pos", rsp_if.next_pos, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_if.next_pos !== want.next_pos)
          report_mismatch("next_pos", rsp_if.next_pos, want.next_pos);
        if (rsp_if.out_valid !== want.out_valid)
          report_mismatch("out_valid", 16'(rsp_if.out_valid), 16'(want.out_valid));
        if (rsp_if.out_char !== want.out_char)
          report_mismatch("out_char", 16'(rsp_if.out_char), 16'(want.out_char));
        if (rsp_if.status !== want.status)
          report_mismatch("status", 16'(rsp_if.status), 16'(want.status));
      end
      results_seen++;
      hold = draw_gap();
      if (results_seen == 350 || results_seen == 1200) hold += HOLD_CYCLES;
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Bound the run; covers the clearing pass and the worst idling on both
  // sides several times over.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] lim;
    logic [15:0] p;
    logic [7:0]  op;
    req_if.valid   = 1'b0;
    req_if.instr   = '0;
    req_if.pos     = '0;
    req_if.in_char = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    foreach (cell_mem[i]) cell_mem[i] = '0;

    //      op                pos       ch     next      ov    oc
    row_exp(tme_pkg::OpDot,   16'd0,    8'h00, 16'd1,    1'b1, 8'h00);  // fresh tape reads 0
    row_exp(tme_pkg::OpMinus, 16'd1,    8'h00, 16'd2,    1'b0, 8'h00);  // 0 wraps to max
    row_exp(tme_pkg::OpDot,   16'd2,    8'h00, 16'd3,    1'b1, 8'h03);  // low byte of 259
    row_exp(tme_pkg::OpPlus,  16'd3,    8'h00, 16'd4,    1'b0, 8'h00);  // at max wraps to 0
    row_exp(tme_pkg::OpComma, 16'd4,    8'hFF, 16'd5,    1'b0, 8'h00);
    row_exp(tme_pkg::OpDot,   16'd5,    8'h00, 16'd6,    1'b1, 8'hFF);
    row_exp(tme_pkg::OpLeft,  16'hFFFF, 8'h00, 16'h0000, 1'b0, 8'h00);  // pointer, pos wrap
    row_exp(tme_pkg::OpComma, 16'd100,  8'h5A, 16'd101,  1'b0, 8'h00);
    row_exp(tme_pkg::OpDot,   16'h8000, 8'h00, 16'h8001, 1'b1, 8'h5A);
    row_exp(tme_pkg::OpRight, 16'd101,  8'h00, 16'd102,  1'b0, 8'h00);  // back to cell 0
    row_exp(8'hFF,            16'h7FFF, 8'hFF, 16'h8000, 1'b0, 8'h00);  // not a command
    row_exp(tme_pkg::OpOpen,  16'd200,  8'h00, 16'd201,  1'b0, 8'h00);  // enter loop
    row_exp(tme_pkg::OpMinus, 16'd201,  8'h00, 16'd202,  1'b0, 8'h00);
    row_exp(tme_pkg::OpClose, 16'd202,  8'h00, 16'd200,  1'b0, 8'h00);  // back to loop start
    row_exp(tme_pkg::OpRight, 16'd300,  8'h00, 16'd301,  1'b0, 8'h00);  // zero cell
    row_exp(tme_pkg::OpOpen,  16'd301,  8'h00, 16'd302,  1'b0, 8'h00);  // start skipping
    row_exp(tme_pkg::OpOpen,  16'd302,  8'h00, 16'd303,  1'b0, 8'h00);  // nested open
    row_exp(tme_pkg::OpDot,   16'd303,  8'h00, 16'd304,  1'b0, 8'h00);  // no output skipping
    row_exp(tme_pkg::OpPlus,  16'd304,  8'h00, 16'd305,  1'b0, 8'h00);
    row_exp(tme_pkg::OpClose, 16'd305,  8'h00, 16'd306,  1'b0, 8'h00);
    row_exp(tme_pkg::OpClose, 16'd306,  8'h00, 16'd307,  1'b0, 8'h00);  // match ends it
    row_exp(tme_pkg::OpDot,   16'd307,  8'h00, 16'd308,  1'b1, 8'h00);  // skipped plus no mark
    row_cfg(16'd1);
    row    (tme_pkg::OpComma, 16'd400,  8'hC8);                          // cell above the limit
    row    (tme_pkg::OpMinus, 16'd401,  8'h00);                          // lowers by one
    row    (tme_pkg::OpPlus,  16'd402,  8'h00);                          // wraps to zero
    row    (tme_pkg::OpMinus, 16'd403,  8'h00);
    row_cfg(16'hFFFF);
    row    (tme_pkg::OpMinus, 16'd404,  8'h00);
    row    (tme_pkg::OpMinus, 16'd405,  8'h00);
    row    (tme_pkg::OpDot,   16'd406,  8'h00);
    row    (tme_pkg::OpPlus,  16'd407,  8'h00);

    // Hold reset, then release it; the block then clears its tape on its own.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].cfg_write) write_cell_max(script[i].cfg_value);
      else send_request(script[i].op, script[i].pos, script[i].ch, script[i].typed,
                        script[i].want);
    end

    // Random programs, one limit setting per phase. Phase 2 runs without
    // idling, phase 3 builds a deep loop stack.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       lim = tme_pkg::CellMaxReset;
        1:       lim = 16'($urandom_range(1, 16));
        2:       lim = 16'hFFFF;
        3:       lim = 16'd1;
        4:       lim = 16'($urandom_range(1, 65535));
        default: lim = 16'($urandom_range(2, 600));
      endcase
      write_cell_max(lim);
      quiet = (ph == 2);
      repeat (PHASE_ITEMS) random_request(ph == 3);
    end
    quiet = 1'b0;

    // Leave any skip in progress before forcing an error.
    while (skip_level != '0)
      send_request(tme_pkg::OpClose, 16'($urandom_range(0, 65535)), 8'h00);

    // Finish with one error, picked at random; it sticks until reset.
    p = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 2))
      0: begin
        // Unmatched close: unwind the stack, then close once more.
        while (loop_depth != 0) begin
          send_request(tme_pkg::OpRight, 16'($urandom_range(0, 65535)), 8'h00);
          send_request(tme_pkg::OpClose, 16'($urandom_range(0, 65535)), 8'h00);
        end
        send_request(tme_pkg::OpClose, p, 8'h00, 1'b1,
                     outcome(p, 1'b0, 8'h00, tme_pkg::StUnmatched));
      end
      1: begin
        // Empty loop: open on a nonzero cell and close right away.
        send_request(tme_pkg::OpComma, 16'($urandom_range(0, 65535)), 8'h01);
        while (loop_depth >= STACK_DEPTH)
          send_request(tme_pkg::OpClose, 16'($urandom_range(0, 65535)), 8'h00);
        send_request(tme_pkg::OpOpen, p, 8'h00);
        send_request(tme_pkg::OpClose, 16'($urandom_range(0, 65535)), 8'h00, 1'b1,
                     outcome(p, 1'b0, 8'h00, tme_pkg::StEmptyLoop));
      end
      default: begin
        // Stack overflow: fill every loop slot, then open one more.
        send_request(tme_pkg::OpComma, 16'($urandom_range(0, 65535)), 8'h01);
        while (loop_depth < STACK_DEPTH)
          send_request(tme_pkg::OpOpen, 16'($urandom_range(0, 65535)), 8'h00);
        send_request(tme_pkg::OpOpen, p, 8'h00, 1'b1,
                     outcome(p, 1'b0, 8'h00, tme_pkg::StOverflow));
      end
    endcase

    // Halted: every byte answers with its own position and the held status.
    repeat (8) begin
      p  = 16'($urandom_range(0, 65535));
      op = ($urandom_range(0, 1) == 1) ? tme_pkg::OpDot : 8'($urandom_range(0, 255));
      send_request(op, p, 8'($urandom_range(0, 255)), 1'b1, outcome(p, 1'b0, 8'h00, halt));
    end

    // Drain, then allow the pipeline depth for any stray result.
    drain_requests();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
